[src/usbcfg_pkg.sv]
`default_nettype none
package usbcfg_pkg;

  // table limits
  localparam int unsigned MAX_IFACES    = 8;
  localparam int unsigned MAX_ENDPOINTS = 16;
  localparam int unsigned MAX_BYTES     = 256;

  // descriptor constants
  localparam logic [7:0] TYPE_IFACE    = 8'd4;
  localparam logic [7:0] TYPE_EP       = 8'd5;
  localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;
  localparam logic [7:0] DESC_MIN_LEN  = 8'd2;
  localparam logic [8:0] SET_MIN_LEN   = 9'd9;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_IFACE   = 2'd0,
    KIND_EP      = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // one result transaction
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  iface_slot;
    logic [3:0]  ep_slot;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic [7:0]  value_c;
    logic [7:0]  value_d;
    logic [7:0]  value_e;
    logic [15:0] max_pkt_size;
    logic        status;
  } result_t;

  // everything one input byte causes: an optional record and an optional summary
  typedef struct packed {
    logic       rec_valid;
    result_t    rec;
    logic       sum_valid;
    logic [3:0] sum_ifaces;
    logic [7:0] sum_config;
    logic       sum_short;
  } entry_t;

endpackage
`default_nettype wire

[src/usbcfg_front.sv]
`default_nettype none
module usbcfg_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 last_i,
  output      logic                 entry_valid_o,
  output      usbcfg_pkg::entry_t   entry_o
);

  logic [8:0]  byte_count_q, byte_count_d;
  logic [7:0]  header_skip_q, header_skip_d;
  logic [7:0]  desc_offset_q, desc_offset_d;
  logic [7:0]  desc_length_q, desc_length_d;
  logic [7:0]  desc_kind_q, desc_kind_d;
  logic [47:0] cap_q, cap_d;
  logic        stopped_q, stopped_d;
  logic [3:0]  iface_count_q, iface_count_d;
  logic        cur_valid_q, cur_valid_d;
  logic [4:0]  ep_count_q, ep_count_d;
  logic [7:0]  config_q, config_d;

  logic        in_range;
  logic        walk;
  logic [2:0]  cap_idx;
  logic [5:0]  cap_lsb;
  logic        rec_valid;
  usbcfg_pkg::result_t rec;

  // per-byte walk of the descriptor chain
  always_comb begin
    byte_count_d  = byte_count_q;
    header_skip_d = header_skip_q;
    desc_offset_d = desc_offset_q;
    desc_length_d = desc_length_q;
    desc_kind_d   = desc_kind_q;
    cap_d         = cap_q;
    stopped_d     = stopped_q;
    iface_count_d = iface_count_q;
    cur_valid_d   = cur_valid_q;
    ep_count_d    = ep_count_q;
    config_d      = config_q;
    rec_valid     = 1'b0;
    rec           = '0;
    walk          = 1'b0;
    cap_idx       = 3'(desc_offset_q - 8'd2);
    cap_lsb       = {cap_idx, 3'b000};

    in_range = byte_count_q < 9'(usbcfg_pkg::MAX_BYTES);
    if (in_range) begin
      if (byte_count_q == 9'd0) header_skip_d = data_byte_i;
      if (byte_count_q == 9'd5) config_d = data_byte_i;
      walk = !stopped_q && (byte_count_q >= {1'b0, header_skip_d});
      byte_count_d = byte_count_q + 9'd1;
    end

    if (walk) begin
      if (desc_offset_q == 8'd0) begin
        // length byte
        desc_length_d = data_byte_i;
        if (data_byte_i < usbcfg_pkg::DESC_MIN_LEN) stopped_d = 1'b1;
        else desc_offset_d = 8'd1;
      end else begin
        if (desc_offset_q == 8'd1) desc_kind_d = data_byte_i;
        else if (desc_offset_q <= 8'd7) cap_d[cap_lsb +: 8] = data_byte_i;

        if ({1'b0, desc_offset_q} + 9'd1 == {1'b0, desc_length_q}) begin
          // final byte of this descriptor
          if (desc_kind_d == usbcfg_pkg::TYPE_IFACE &&
              desc_length_q >= usbcfg_pkg::IFACE_MIN_LEN) begin
            if (iface_count_q < 4'(usbcfg_pkg::MAX_IFACES)) begin
              rec_valid      = 1'b1;
              rec.kind       = usbcfg_pkg::KIND_IFACE;
              rec.iface_slot = iface_count_q;
              rec.value_a    = cap_d[7:0];
              rec.value_b    = cap_d[15:8];
              rec.value_c    = cap_d[31:24];
              rec.value_d    = cap_d[39:32];
              rec.value_e    = cap_d[47:40];
              iface_count_d  = iface_count_q + 4'd1;
              cur_valid_d    = 1'b1;
              ep_count_d     = 5'd0;
            end else begin
              cur_valid_d = 1'b0;
            end
          end else if (desc_kind_d == usbcfg_pkg::TYPE_EP &&
                       desc_length_q >= usbcfg_pkg::EP_MIN_LEN && cur_valid_q) begin
            if (ep_count_q < 5'(usbcfg_pkg::MAX_ENDPOINTS)) begin
              rec_valid        = 1'b1;
              rec.kind         = usbcfg_pkg::KIND_EP;
              rec.iface_slot   = iface_count_q - 4'd1;
              rec.ep_slot      = ep_count_q[3:0];
              rec.value_a      = cap_d[7:0];
              rec.value_b      = cap_d[15:8];
              rec.value_c      = cap_d[39:32];
              rec.max_pkt_size = cap_d[31:16];
              ep_count_d       = ep_count_q + 5'd1;
            end
          end
          desc_offset_d = 8'd0;
        end else begin
          desc_offset_d = desc_offset_q + 8'd1;
        end
      end
    end

    // queue entry
    entry_o.rec_valid  = rec_valid;
    entry_o.rec        = rec;
    entry_o.sum_valid  = last_i;
    entry_o.sum_ifaces = iface_count_d;
    entry_o.sum_short  = byte_count_d < usbcfg_pkg::SET_MIN_LEN;
    entry_o.sum_config = entry_o.sum_short ? 8'd0 : config_d;
    entry_valid_o      = accept_i && (rec_valid || last_i);

    // end of set clears the walk
    if (last_i) begin
      byte_count_d  = '0;
      header_skip_d = '0;
      desc_offset_d = '0;
      desc_length_d = '0;
      desc_kind_d   = '0;
      cap_d         = '0;
      stopped_d     = 1'b0;
      iface_count_d = '0;
      cur_valid_d   = 1'b0;
      ep_count_d    = '0;
      config_d      = '0;
    end
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      header_skip_q <= '0;
      desc_offset_q <= '0;
      desc_length_q <= '0;
      desc_kind_q   <= '0;
      cap_q         <= '0;
      stopped_q     <= 1'b0;
      iface_count_q <= '0;
      cur_valid_q   <= 1'b0;
      ep_count_q    <= '0;
      config_q      <= '0;
    end else if (accept_i) begin
      byte_count_q  <= byte_count_d;
      header_skip_q <= header_skip_d;
      desc_offset_q <= desc_offset_d;
      desc_length_q <= desc_length_d;
      desc_kind_q   <= desc_kind_d;
      cap_q         <= cap_d;
      stopped_q     <= stopped_d;
      iface_count_q <= iface_count_d;
      cur_valid_q   <= cur_valid_d;
      ep_count_q    <= ep_count_d;
      config_q      <= config_d;
    end
  end

endmodule
`default_nettype wire

[src/usbcfg_fifo.sv]
`default_nettype none
module usbcfg_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire usbcfg_pkg::entry_t wr_data_i,
  input  wire logic               rd_i,
  output      usbcfg_pkg::entry_t rd_data_o,
  output      logic               full_o,
  output      logic               empty_o
);

  localparam int unsigned PtrW = usbcfg_pkg::FIFO_PTR_W;

  usbcfg_pkg::entry_t mem_q [usbcfg_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o    = count_q == (PtrW+1)'(usbcfg_pkg::FIFO_DEPTH);
  assign empty_o   = count_q == '0;
  assign rd_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (rd_i) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (wr_i && !rd_i) count_q <= count_q + (PtrW+1)'(1);
      else if (rd_i && !wr_i) count_q <= count_q - (PtrW+1)'(1);
    end
  end

endmodule
`default_nettype wire

[src/usbcfg_back.sv]
`default_nettype none
module usbcfg_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 head_valid_i,
  input  wire usbcfg_pkg::entry_t   head_i,
  output      logic                 head_pop_o,
  output      logic                 out_valid_o,
  output      usbcfg_pkg::result_t  out_o,
  output      logic                 out_last_o,
  input  wire logic                 out_pop_i
);

  logic                out_valid_q;
  usbcfg_pkg::result_t out_q, out_d;
  logic                last_q, last_d;
  logic                phase_q, phase_d;
  logic                load;

  assign load        = head_valid_i && (!out_valid_q || out_pop_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_last_o  = last_q;

  // pick record first, then summary, from the queue head
  always_comb begin
    phase_d    = phase_q;
    head_pop_o = 1'b0;
    out_d      = head_i.rec;
    last_d     = !head_i.sum_valid;
    if (load) begin
      if (head_i.rec_valid && !phase_q) begin
        out_d  = head_i.rec;
        last_d = !head_i.sum_valid;
        if (head_i.sum_valid) phase_d = 1'b1;
        else head_pop_o = 1'b1;
      end else begin
        out_d            = '0;
        out_d.kind       = usbcfg_pkg::KIND_SUMMARY;
        out_d.iface_slot = head_i.sum_ifaces;
        out_d.value_a    = head_i.sum_config;
        out_d.status     = head_i.sum_short;
        last_d           = 1'b1;
        phase_d          = 1'b0;
        head_pop_o       = 1'b1;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= out_d;
      last_q <= last_d;
    end
  end

  // output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[src/usb_config_descriptor_parser_top.sv]
`default_nettype none
// Parses a USB configuration descriptor set fed one byte per transaction, with
// last on the final byte. An input byte is taken every cycle while full is
// low; the front walks the descriptor chain in that same cycle and writes what
// the byte causes (an interface or endpoint record, and on last a summary) as
// one entry into a four-entry queue. The back drains the queue into the output
// register at one result per cycle while results are popped, so a byte
// that gives both a record and a summary yields the record, then the summary.
// Full rises only when the output side has stalled long enough to fill the
// queue. last_of_run_o marks the final result caused by one byte. No clearing
// pass is needed after reset.
module usb_config_descriptor_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [1:0]  kind_o,
  output      logic [3:0]  iface_slot_o,
  output      logic [3:0]  ep_slot_o,
  output      logic [7:0]  value_a_o,
  output      logic [7:0]  value_b_o,
  output      logic [7:0]  value_c_o,
  output      logic [7:0]  value_d_o,
  output      logic [7:0]  value_e_o,
  output      logic [15:0] max_pkt_size_o,
  output      logic        status_o,
  output      logic        last_of_run_o
);

  logic                accept;
  logic                entry_valid;
  usbcfg_pkg::entry_t  entry;
  usbcfg_pkg::entry_t  head;
  logic                q_full, q_empty, head_pop;
  logic                out_valid;
  usbcfg_pkg::result_t out_res;

  assign full   = q_full;
  assign accept = push && !q_full;

  // byte walk
  usbcfg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  // decoupling queue
  usbcfg_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (entry_valid),
    .wr_data_i (entry),
    .rd_i      (head_pop),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // result sequencing
  usbcfg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .out_valid_o  (out_valid),
    .out_o        (out_res),
    .out_last_o   (last_of_run_o),
    .out_pop_i    (pop)
  );

  // result ports
  assign empty          = !out_valid;
  assign kind_o         = out_res.kind;
  assign iface_slot_o   = out_res.iface_slot;
  assign ep_slot_o      = out_res.ep_slot;
  assign value_a_o      = out_res.value_a;
  assign value_b_o      = out_res.value_b;
  assign value_c_o      = out_res.value_c;
  assign value_d_o      = out_res.value_d;
  assign value_e_o      = out_res.value_e;
  assign max_pkt_size_o = out_res.max_pkt_size;
  assign status_o       = out_res.status;

endmodule
`default_nettype wire

[tb/tb_usb_config_descriptor_parser_top.sv]
`timescale 1ns / 1ps
module tb_usb_config_descriptor_parser_top;

  // one expected result transaction plus its end-of-run flag
  typedef struct packed {
    usbcfg_pkg::result_t res;
    logic                last_of_run;
  } parse_result_t;

  // one row of the directed table
  typedef struct packed {
    logic [7:0]    data;
    logic          last;
    logic          typed;
    parse_result_t want;
  } byte_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic last_i = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [1:0] kind_o;
  logic [3:0] iface_slot_o;
  logic [3:0] ep_slot_o;
  logic [7:0] value_a_o;
  logic [7:0] value_b_o;
  logic [7:0] value_c_o;
  logic [7:0] value_d_o;
  logic [7:0] value_e_o;
  logic [15:0] max_pkt_size_o;
  logic status_o;
  logic last_of_run_o;

  // receiver hold-off request
  logic hold_rx = 1'b0;

  parse_result_t pending_results[$];
  parse_result_t new_results[$];
  byte_row_t directed_rows[$];
  logic [7:0] set_bytes[$];
  int unsigned items_done = 0;
  int unsigned mismatch_count = 0;

  // parser state mirrored by the predictor
  logic [8:0] seen_bytes;
  logic [7:0] hdr_skip;
  logic [7:0] desc_pos;
  logic [7:0] desc_len;
  logic [7:0] desc_type;
  logic [7:0] desc_bytes [2:7];
  logic       walk_stopped;
  logic [3:0] n_ifaces;
  logic       iface_open;
  logic [4:0] n_eps;
  logic [7:0] cfg_val;

  usb_config_descriptor_parser_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .iface_slot_o   (iface_slot_o),
    .ep_slot_o      (ep_slot_o),
    .value_a_o      (value_a_o),
    .value_b_o      (value_b_o),
    .value_c_o      (value_c_o),
    .value_d_o      (value_d_o),
    .value_e_o      (value_e_o),
    .max_pkt_size_o (max_pkt_size_o),
    .status_o       (status_o),
    .last_of_run_o  (last_of_run_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // clear the mirrored parser state
  task automatic clear_parser();
    seen_bytes   = '0;
    hdr_skip     = '0;
    desc_pos     = '0;
    desc_len     = '0;
    desc_type    = '0;
    walk_stopped = 1'b0;
    n_ifaces     = '0;
    iface_open   = 1'b0;
    n_eps        = '0;
    cfg_val      = '0;
    for (int k = 2; k <= 7; k++) desc_bytes[k] = '0;
  endtask

  // predict the results one byte causes, left in new_results
  task automatic parse_byte(input logic [7:0] b, input logic l);
    parse_result_t rec;
    parse_result_t sum;
    bit have_rec;
    int unsigned pos;
    int unsigned off;
    rec = '0;
    sum = '0;
    have_rec = 1'b0;
    new_results.delete();
    if (seen_bytes < usbcfg_pkg::MAX_BYTES) begin
      pos = seen_bytes;
      if (pos == 0) hdr_skip = b;
      if (pos == 5) cfg_val = b;
      // descriptor chain walk
      if (!walk_stopped && pos >= hdr_skip) begin
        if (desc_pos == 0) begin
          desc_len = b;
          if (b < usbcfg_pkg::DESC_MIN_LEN) walk_stopped = 1'b1;
          else desc_pos = 8'd1;
        end else begin
          off = desc_pos;
          if (off == 1) desc_type = b;
          else if (off <= 7) desc_bytes[off] = b;
          if (off + 1 == desc_len) begin
            if (desc_type == usbcfg_pkg::TYPE_IFACE &&
                desc_len >= usbcfg_pkg::IFACE_MIN_LEN) begin
              if (n_ifaces < usbcfg_pkg::MAX_IFACES) begin
                rec.res.kind       = usbcfg_pkg::KIND_IFACE;
                rec.res.iface_slot = n_ifaces;
                rec.res.value_a    = desc_bytes[2];
                rec.res.value_b    = desc_bytes[3];
                rec.res.value_c    = desc_bytes[5];
                rec.res.value_d    = desc_bytes[6];
                rec.res.value_e    = desc_bytes[7];
                n_ifaces   = n_ifaces + 4'd1;
                iface_open = 1'b1;
                n_eps      = '0;
                have_rec   = 1'b1;
              end else begin
                iface_open = 1'b0;
              end
            end else if (desc_type == usbcfg_pkg::TYPE_EP &&
                         desc_len >= usbcfg_pkg::EP_MIN_LEN && iface_open) begin
              if (n_eps < usbcfg_pkg::MAX_ENDPOINTS) begin
                rec.res.kind         = usbcfg_pkg::KIND_EP;
                rec.res.iface_slot   = n_ifaces - 4'd1;
                rec.res.ep_slot      = n_eps[3:0];
                rec.res.value_a      = desc_bytes[2];
                rec.res.value_b      = desc_bytes[3];
                rec.res.value_c      = desc_bytes[6];
                rec.res.max_pkt_size = {desc_bytes[5], desc_bytes[4]};
                n_eps    = n_eps + 5'd1;
                have_rec = 1'b1;
              end
            end
            desc_pos = '0;
          end else begin
            desc_pos = desc_pos + 8'd1;
          end
        end
      end
      seen_bytes = seen_bytes + 9'd1;
    end
    if (have_rec) begin
      rec.last_of_run = !l;
      new_results.push_back(rec);
    end
    // end summary on last
    if (l) begin
      sum.res.kind       = usbcfg_pkg::KIND_SUMMARY;
      sum.res.iface_slot = n_ifaces;
      if (seen_bytes < usbcfg_pkg::SET_MIN_LEN) sum.res.status = 1'b1;
      else sum.res.value_a = cfg_val;
      sum.last_of_run = 1'b1;
      new_results.push_back(sum);
      clear_parser();
    end
  endtask

  // offer one byte, wait for its transaction, then record what it should cause
  task automatic offer_byte(input logic [7:0] b, input logic l, input int unsigned gap,
                            input bit drain, input bit typed, input parse_result_t want);
    if (drain || gap != 0) begin
      push <= 1'b0;
      if (drain) begin
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_i      <= l;
    do @(posedge clk_i); while (full);
    if (seen_bytes < usbcfg_pkg::MAX_BYTES || l) items_done++;
    parse_byte(b, l);
    if (typed) pending_results.push_back(want);
    else foreach (new_results[k]) pending_results.push_back(new_results[k]);
  endtask

  // directed table helpers
  task automatic add_row(input logic [7:0] b, input logic l);
    byte_row_t row;
    row = '0;
    row.data = b;
    row.last = l;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed_summary(input logic [7:0] b, input logic [3:0] ifaces,
                                   input logic [7:0] cfg, input logic short_set);
    byte_row_t row;
    row = '0;
    row.data  = b;
    row.last  = 1'b1;
    row.typed = 1'b1;
    row.want.res.kind       = usbcfg_pkg::KIND_SUMMARY;
    row.want.res.iface_slot = ifaces;
    row.want.res.value_a    = cfg;
    row.want.res.status     = short_set;
    row.want.last_of_run    = 1'b1;
    directed_rows.push_back(row);
  endtask

  // append one descriptor with random body bytes
  task automatic add_desc(input logic [7:0] dtype, input int unsigned len);
    set_bytes.push_back(8'(len));
    if (len >= 2) begin
      set_bytes.push_back(dtype);
      repeat (len - 2) set_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // mostly well-formed descriptors, some odd or broken
  task automatic add_random_desc();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) begin
      add_desc(usbcfg_pkg::TYPE_IFACE,
               ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : 9);
    end else if (p < 80) begin
      add_desc(usbcfg_pkg::TYPE_EP,
               ($urandom_range(0, 7) == 0) ? $urandom_range(8, 10) : 7);
    end else if (p < 90) begin
      add_desc(8'($urandom_range(0, 255)), $urandom_range(2, 12));
    end else if (p < 97) begin
      add_desc($urandom_range(0, 1) ? usbcfg_pkg::TYPE_IFACE : usbcfg_pkg::TYPE_EP,
               $urandom_range(2, 8));
    end else begin
      add_desc(8'($urandom_range(0, 255)), $urandom_range(0, 1));
    end
  endtask

  // build one descriptor set into set_bytes
  task automatic make_set(input int unsigned set_no);
    int unsigned pick;
    int unsigned hdr_len;
    int unsigned cut;
    set_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise
      repeat ($urandom_range(1, 24)) set_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      hdr_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : 9;
      set_bytes.push_back(8'(hdr_len));
      set_bytes.push_back(8'd2);
      repeat (7) set_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ((hdr_len > 9) ? hdr_len - 9 : 0) set_bytes.push_back(8'($urandom_range(0, 255)));
      if (set_no == 7) begin
        // runs past the byte cap
        while (set_bytes.size() < 300) add_random_desc();
      end else if (pick < 15) begin
        // more interfaces than slots
        repeat (10) begin
          add_desc(usbcfg_pkg::TYPE_IFACE, 9);
          if ($urandom_range(0, 1) != 0) add_desc(usbcfg_pkg::TYPE_EP, 7);
        end
      end else if (pick < 20) begin
        // more endpoints than slots
        add_desc(usbcfg_pkg::TYPE_IFACE, 9);
        repeat (18) add_desc(usbcfg_pkg::TYPE_EP, 7);
      end else begin
        repeat ($urandom_range(0, 6)) add_random_desc();
      end
      // set cut short
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, set_bytes.size());
        while (set_bytes.size() > cut) void'(set_bytes.pop_back());
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // reset and stimulus
  initial begin : byte_source
    bit burst;
    parse_result_t none;
    none = '0;
    clear_parser();
    // header length zero and too short
    add_typed_summary(8'h00, 4'd0, 8'h00, 1'b1);
    // bare header, extreme config value
    add_row(8'h09, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h09, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h80, 1'b0);
    add_typed_summary(8'h32, 4'd0, 8'hFF, 1'b0);
    // header length below 9, interface then endpoint ending on last
    add_row(8'h02, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h09, 1'b0);
    add_row(8'h04, 1'b0);
    add_row(8'h03, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h07, 1'b0);
    add_row(8'h05, 1'b0);
    add_row(8'h81, 1'b0);
    add_row(8'h03, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h07, 1'b0);
    add_row(8'h0A, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[k]) begin
      offer_byte(directed_rows[k].data, directed_rows[k].last, $urandom_range(0, 15), 1'b0,
                 directed_rows[k].typed, directed_rows[k].want);
    end

    // random descriptor sets
    for (int unsigned set_no = 0; items_done < 1400; set_no++) begin
      make_set(set_no);
      burst = ($urandom_range(0, 3) == 0);
      foreach (set_bytes[k]) begin
        offer_byte(set_bytes[k], k == set_bytes.size() - 1,
                   burst ? 0 : $urandom_range(0, 15), set_no == 10 && k == 0, 1'b0, none);
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: random stalls, compare each transaction
  initial begin : result_sink
    int unsigned stall;
    bit rx_burst;
    parse_result_t want;
    rx_burst = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if (stall != 0 || hold_rx) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_rx) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.res.kind, kind_o);
        check_field("iface_slot", want.res.iface_slot, iface_slot_o);
        check_field("ep_slot", want.res.ep_slot, ep_slot_o);
        check_field("value_a", want.res.value_a, value_a_o);
        check_field("value_b", want.res.value_b, value_b_o);
        check_field("value_c", want.res.value_c, value_c_o);
        check_field("value_d", want.res.value_d, value_d_o);
        check_field("value_e", want.res.value_e, value_e_o);
        check_field("max_pkt_size", want.res.max_pkt_size, max_pkt_size_o);
        check_field("status", want.res.status, status_o);
        check_field("last_of_run", want.last_of_run, last_of_run_o);
      end
    end
  end

  // long receiver hold-off so the queue fills and full rises
  initial begin : rx_hold_off
    wait (items_done >= 500);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // run limit
  initial begin : run_limit
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
